// ----- src/spq_pkg.sv -----
// Shared types and codes for the sorted priority queue.
// Used by spq_cell and sorted_priority_queue_top; depends on nothing else.
package spq_pkg;

	// Operation selector carried on the op input.
	typedef enum logic [1:0] {
		OP_PUSH   = 2'd0,
		OP_POP    = 2'd1,
		OP_STATUS = 2'd2
	} spq_op_t;

	// Fault code reported with every result.
	typedef enum logic [1:0] {
		FAULT_NONE  = 2'd0,
		FAULT_EMPTY = 2'd1,
		FAULT_FULL  = 2'd2
	} spq_fault_t;

	// One stored entry: data word and priority.
	typedef struct packed {
		logic [31:0] value;
		logic [15:0] rank;
	} spq_entry_t;

	// Per-cycle command broadcast to every cell of the chain.
	typedef struct packed {
		logic push;
		logic pop;
	} spq_cmd_t;

endpackage

// ----- src/spq_cell.sv -----
// One cell of the sorted chain: holds a single entry and moves it by one place.
// Depends on spq_pkg for the entry and command types.
module spq_cell
	import spq_pkg::*;
(
	input  logic       clk,
	input  spq_cmd_t   cmd,
	input  logic       occupied,
	input  spq_entry_t new_entry,
	input  spq_entry_t left_entry,
	input  logic       left_keep,
	input  spq_entry_t right_entry,
	output logic       keep,
	output spq_entry_t entry
);

	spq_entry_t entry_q;

	// A cell keeps its place on a push when it holds an entry that is served
	// no later than the new one; ties stay ahead so equal ranks leave in order.
	assign keep  = occupied && ($signed(entry_q.rank) <= $signed(new_entry.rank));
	assign entry = entry_q;

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			if (!keep) begin
				entry_q <= left_keep ? new_entry : left_entry;
			end
		end else if (cmd.pop) begin
			entry_q <= right_entry;
		end
	end

endmodule

// ----- src/sorted_priority_queue_top.sv -----
// Top level of the sorted priority queue: a chain of spq_cell instances,
// the fill counter and the result register. Depends on spq_pkg and spq_cell.
//
//   channel | signals                                    | role
//   --------+--------------------------------------------+---------------------------
//   in      | in_valid, in_stall, op, item_value,        | one operation per
//           | item_rank                                  | transaction
//   out     | out_valid, out_stall, popped_value,        | one result per accepted
//           | head_value, head_rank, is_empty, is_full,  | input transaction
//           | fault                                      |
//
// All cells compare against the new rank and shift by one place in the same
// edge, so a new operation can enter each cycle unless in_stall holds it off.
// The result is registered and appears in the cycle after acceptance.
// Reset (arst_n low) empties the queue; cell contents are not cleared since
// only cells below the fill count are ever observed.
// in_stall is high only while a result is held and out_stall is high.
module sorted_priority_queue_top
	import spq_pkg::*;
#(
	parameter int DEPTH = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         op,
	input  logic signed [31:0] item_value,
	input  logic signed [15:0] item_rank,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] popped_value,
	output logic signed [31:0] head_value,
	output logic signed [15:0] head_rank,
	output logic               is_empty,
	output logic               is_full,
	output logic [1:0]         fault
);

	localparam int CW = $clog2(DEPTH + 1);

	// Fill count; cell i holds a live entry exactly when i < count_q.
	logic [CW-1:0] count_q;
	logic          out_valid_q;
	logic [31:0]   popped_q;
	spq_fault_t    fault_q;

	logic       accept;
	logic       q_empty;
	logic       q_full;
	logic       is_push;
	logic       is_pop;
	spq_cmd_t   cmd;
	spq_fault_t fault_nxt;
	spq_entry_t new_entry;

	spq_entry_t cell_entry [DEPTH];
	logic       cell_keep  [DEPTH];

	assign q_empty = (count_q == '0);
	assign q_full  = (count_q == CW'(DEPTH));

	// A new transaction can enter whenever the result slot is free or is
	// being emptied in this same cycle.
	assign in_stall = out_valid_q && out_stall;
	assign accept   = in_valid && !in_stall;

	// Codes other than push and pop behave as a status request.
	assign is_push = (op == OP_PUSH);
	assign is_pop  = (op == OP_POP);

	assign cmd.push = accept && is_push && !q_full;
	assign cmd.pop  = accept && is_pop && !q_empty;

	assign new_entry.value = item_value;
	assign new_entry.rank  = item_rank;

	always_comb begin
		fault_nxt = FAULT_NONE;
		if (is_push && q_full) begin
			fault_nxt = FAULT_FULL;
		end else if (is_pop && q_empty) begin
			fault_nxt = FAULT_EMPTY;
		end
	end

	// The chain: on a push the first cell that does not keep its entry takes
	// the new one and every cell behind it takes its left neighbor's entry;
	// on a pop every cell takes its right neighbor's entry.
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		spq_entry_t left_entry;
		spq_entry_t right_entry;
		logic       left_keep;
		logic       occupied;

		assign occupied = (count_q > CW'(i));

		if (i == 0) begin : g_first
			assign left_entry = new_entry;
			assign left_keep  = 1'b1;
		end else begin : g_inner
			assign left_entry = cell_entry[i-1];
			assign left_keep  = cell_keep[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign right_entry = cell_entry[i];
		end else begin : g_next
			assign right_entry = cell_entry[i+1];
		end

		spq_cell u_cell (
			.clk         (clk),
			.cmd         (cmd),
			.occupied    (occupied),
			.new_entry   (new_entry),
			.left_entry  (left_entry),
			.left_keep   (left_keep),
			.right_entry (right_entry),
			.keep        (cell_keep[i]),
			.entry       (cell_entry[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.push) begin
				count_q <= count_q + CW'(1);
			end else if (cmd.pop) begin
				count_q <= count_q - CW'(1);
			end
			if (accept) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// The popped word is captured with the transaction; the head and the flags
	// are read straight from the chain, which only moves when the result
	// register is reloaded in the same edge.
	always_ff @(posedge clk) begin
		if (accept) begin
			popped_q <= cmd.pop ? cell_entry[0].value : '0;
			fault_q  <= fault_nxt;
		end
	end

	assign out_valid    = out_valid_q;
	assign popped_value = popped_q;
	assign fault        = fault_q;
	assign is_empty     = q_empty;
	assign is_full      = q_full;
	assign head_value   = q_empty ? '0 : cell_entry[0].value;
	assign head_rank    = q_empty ? '0 : cell_entry[0].rank;

`ifndef SYNTHESIS
	a_count_bound : assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("fill count above depth");

	a_full_push_drops : assert property (@(posedge clk) disable iff (!arst_n)
		(accept && is_push && q_full) |=> $stable(count_q))
		else $error("push on full queue changed the fill count");

	a_pop_decrements : assert property (@(posedge clk) disable iff (!arst_n)
		(accept && is_pop && !q_empty) |=> (count_q == $past(count_q) - CW'(1)))
		else $error("pop did not remove an entry");

	a_full_fault_flag : assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && fault_q == FAULT_FULL) |-> q_full)
		else $error("full fault reported while queue not full");

	a_empty_fault_zero : assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && fault_q == FAULT_EMPTY) |-> (q_empty && popped_q == '0))
		else $error("empty fault with live entries or nonzero data");
`endif

endmodule

// ----- tb/tb_sorted_priority_queue_top.sv -----
// Self-checking testbench for sorted_priority_queue_top: a shadow copy of the
// queue predicts every result; tasks drive input, an always block out_stall.
// Depends on spq_pkg and the block's RTL only.
module tb_sorted_priority_queue_top;
	import spq_pkg::*;

	localparam int QDEPTH = 16;
	// The selector value with no operation behind it; the block treats it as
	// a status request.
	localparam logic [1:0] OP_SPARE = 2'd3;
	// Cycles with no transaction on either channel before the run is abandoned.
	localparam int STALL_LIMIT = 1000;
	// Length of the long receiver hold-off used to back the queue up.
	localparam int HOLD_CYCLES = 80;
	localparam int PHASE_ITEMS = 125;

	// One result transaction, field for field as it leaves the block.
	typedef struct packed {
		logic signed [31:0] popped_value;
		logic signed [31:0] head_value;
		logic signed [15:0] head_rank;
		logic               is_empty;
		logic               is_full;
		logic [1:0]         fault;
	} pq_result_t;

	// Shadow of the queue contents. Every accepted request is applied here
	// and the result it must produce is queued; results leaving the block
	// are compared against the oldest queued one.
	class pq_shadow;
		logic signed [31:0] slot_value [QDEPTH];
		logic signed [15:0] slot_rank [QDEPTH];
		int unsigned held;
		pq_result_t pending_results [$];
		int unsigned mismatches;

		function new();
			held = 0;
			mismatches = 0;
		endfunction

		function void flag(string what, longint want, longint have);
			mismatches++;
			if (mismatches <= 10) begin
				$display("mismatch on %s: expected %0d, got %0d", what, want, have);
			end
		endfunction

		function void note_request(logic [1:0] code, logic signed [31:0] value,
				logic signed [15:0] rank);
			pq_result_t r;
			int unsigned pos;
			r = '0;
			r.fault = FAULT_NONE;
			case (code)
				OP_PUSH: begin
					if (held >= QDEPTH) begin
						r.fault = FAULT_FULL;
					end else begin
						// A new entry goes behind every entry of equal rank.
						pos = 0;
						while (pos < held && slot_rank[pos] <= rank) pos++;
						for (int i = held; i > pos; i--) begin
							slot_value[i] = slot_value[i - 1];
							slot_rank[i] = slot_rank[i - 1];
						end
						slot_value[pos] = value;
						slot_rank[pos] = rank;
						held++;
					end
				end
				OP_POP: begin
					if (held == 0) begin
						r.fault = FAULT_EMPTY;
					end else begin
						r.popped_value = slot_value[0];
						for (int i = 1; i < held; i++) begin
							slot_value[i - 1] = slot_value[i];
							slot_rank[i - 1] = slot_rank[i];
						end
						held--;
					end
				end
				default: ;
			endcase
			if (held > 0) begin
				r.head_value = slot_value[0];
				r.head_rank = slot_rank[0];
			end
			r.is_empty = (held == 0);
			r.is_full = (held >= QDEPTH);
			pending_results.push_back(r);
		endfunction

		function void check_response(pq_result_t got);
			pq_result_t want;
			if (pending_results.size() == 0) begin
				flag("result with no request outstanding", 0, 1);
				return;
			end
			want = pending_results.pop_front();
			if (got.popped_value !== want.popped_value)
				flag("popped_value", want.popped_value, got.popped_value);
			if (got.head_value !== want.head_value)
				flag("head_value", want.head_value, got.head_value);
			if (got.head_rank !== want.head_rank)
				flag("head_rank", want.head_rank, got.head_rank);
			if (got.is_empty !== want.is_empty)
				flag("is_empty", want.is_empty, got.is_empty);
			if (got.is_full !== want.is_full)
				flag("is_full", want.is_full, got.is_full);
			if (got.fault !== want.fault)
				flag("fault", want.fault, got.fault);
		endfunction
	endclass

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [1:0]         op = OP_STATUS;
	logic signed [31:0] item_value = '0;
	logic signed [15:0] item_rank = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic signed [31:0] popped_value;
	logic signed [31:0] head_value;
	logic signed [15:0] head_rank;
	logic               is_empty;
	logic               is_full;
	logic [1:0]         fault;

	pq_shadow shadow = new();

	// Idle and stall rates of the current phase, in percent.
	int unsigned idle_pct = 0;
	int unsigned stall_pct = 0;
	// Set by the sender to ask the receiver for one long hold-off.
	bit hold_req = 1'b0;
	int unsigned hold_left = 0;
	int unsigned quiet = 0;
	bit progress;
	pq_result_t got;
	// Random requests alternate between filling and draining the queue.
	bit fill_mode = 1'b1;

	always #1 clk = ~clk;

	sorted_priority_queue_top #(
		.DEPTH(QDEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.op(op),
		.item_value(item_value),
		.item_rank(item_rank),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.popped_value(popped_value),
		.head_value(head_value),
		.head_rank(head_rank),
		.is_empty(is_empty),
		.is_full(is_full),
		.fault(fault)
	);

	// Receiver: stalls at random at the phase's rate. A hold-off request
	// keeps the stall high for a fixed stretch, counted here, so that the
	// block's result register fills and it pushes back on its input.
	always @(negedge clk) begin
		if (hold_req) begin
			hold_left = HOLD_CYCLES;
			hold_req = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	// Monitor on the rising edge. The result is checked before the request of
	// the same edge is noted, so a result can never match a request that was
	// only just accepted. The watchdog counts cycles without any transaction.
	always @(posedge clk) begin
		if (arst_n) begin
			progress = 1'b0;
			if (out_valid && !out_stall) begin
				got.popped_value = popped_value;
				got.head_value = head_value;
				got.head_rank = head_rank;
				got.is_empty = is_empty;
				got.is_full = is_full;
				got.fault = fault;
				shadow.check_response(got);
				progress = 1'b1;
			end
			if (in_valid && !in_stall) begin
				shadow.note_request(op, item_value, item_rank);
				progress = 1'b1;
			end
			if (progress) begin
				quiet = 0;
			end else begin
				quiet++;
				if (quiet >= STALL_LIMIT) begin
					$display("TB_ERROR");
					$finish;
				end
			end
		end
	end

	// Waits out the sender's idle cycles and lands on the falling edge at
	// which the next transaction is driven. The shadow is settled by then.
	task automatic next_slot();
		while ($urandom_range(99) < idle_pct) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
		@(negedge clk);
	endtask

	// Offers one request and holds it until the block accepts it. Valid is
	// left high, so back-to-back requests never lower and raise it in one step.
	task automatic offer(input logic [1:0] code, input logic signed [31:0] value,
			input logic signed [15:0] rank);
		in_valid <= 1'b1;
		op <= code;
		item_value <= value;
		item_rank <= rank;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic issue(input logic [1:0] code, input logic signed [31:0] value,
			input logic signed [15:0] rank);
		next_slot();
		offer(code, value, rank);
	endtask

	// Stops offering and waits until every expected result has come back.
	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (shadow.pending_results.size() != 0) @(negedge clk);
	endtask

	// Builds one random request. Most requests follow the current fill or
	// drain direction, so the queue swings between empty and full and both
	// overflow and underflow occur; ranks are often drawn from a narrow band
	// to produce plenty of ties.
	task automatic random_request();
		logic [1:0] code;
		logic signed [15:0] rank;
		int unsigned roll;
		if (fill_mode && shadow.held == QDEPTH && $urandom_range(99) < 30)
			fill_mode = 1'b0;
		else if (!fill_mode && shadow.held == 0 && $urandom_range(99) < 30)
			fill_mode = 1'b1;
		roll = $urandom_range(99);
		if (roll < 4)
			code = OP_STATUS;
		else if (roll < 8)
			code = OP_SPARE;
		else if (roll < 78)
			code = fill_mode ? OP_PUSH : OP_POP;
		else
			code = fill_mode ? OP_POP : OP_PUSH;
		roll = $urandom_range(99);
		if (roll < 50) begin
			rank = 16'($signed($urandom_range(6)) - 3);
		end else if (roll < 65) begin
			case ($urandom_range(3))
				0: rank = 16'sh7fff;
				1: rank = 16'sh8000;
				2: rank = 16'sh0000;
				default: rank = -16'sd1;
			endcase
		end else begin
			rank = 16'($urandom);
		end
		offer(code, $urandom, rank);
	endtask

	// Directed pushes that fill the queue exactly: the rank extremes, the
	// extreme data words, and ties at zero and at both rank extremes.
	logic signed [31:0] dir_value [QDEPTH] = '{
		32'sh7fffffff, 32'sh80000000, 1, -1, 2, 3, 4, 5,
		6, 7, 8, 9, 10, 11, 12, 13
	};
	logic signed [15:0] dir_rank [QDEPTH] = '{
		0, 0, 16'sh7fff, 16'sh8000, 0, 16'sh7fff, 16'sh8000, 5,
		-5, 5, 1, -1, 100, -100, 5, 0
	};

	int unsigned phase_idle [4] = '{0, 51, 0, 16};
	int unsigned phase_stall [4] = '{0, 0, 51, 16};

	initial begin
		repeat (12) @(negedge clk);
		arst_n = 1'b1;

		// Directed part: status, underflow and the spare selector on an
		// empty queue, then a fill to capacity, an overflow, a status on the
		// full queue and a few pops that show the tie order.
		issue(OP_STATUS, 0, 0);
		issue(OP_POP, 32'sh5a5a5a5a, 0);
		issue(OP_SPARE, -1, -1);
		for (int i = 0; i < QDEPTH; i++) issue(OP_PUSH, dir_value[i], dir_rank[i]);
		issue(OP_PUSH, 14, -7);
		issue(OP_STATUS, 0, 0);
		repeat (4) issue(OP_POP, 0, 0);

		// Random part in four phases of sender idling and receiver stalling.
		for (int p = 0; p < 4; p++) begin
			idle_pct = phase_idle[p];
			stall_pct = phase_stall[p];
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				// With no sender idling, a long receiver hold-off lets the
				// queue back up until the block stalls its input.
				if (p == 0 && n == 60) hold_req = 1'b1;
				// Once, the sender goes quiet until every result is back.
				if (p == 1 && n == 60) drain();
				next_slot();
				random_request();
			end
		end

		drain();
		repeat (8) @(posedge clk);
		if (shadow.mismatches == 0 && shadow.pending_results.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
